/* rtl/hic_pkg.sv */
package hic_pkg;

    localparam int COORD_W = 32;
    localparam int AXIS_W  = 3;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] DIMS_RESET = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PROC,
        ST_EMIT
    } state_t;

endpackage

/* rtl/hic_gray_rot.sv */
module hic_gray_rot #(
    parameter int W  = 8,
    parameter int DW = 4
) (
    input  logic [W-1:0]  s,
    input  logic [W-1:0]  e,
    input  logic [W-1:0]  msk,
    input  logic [W-1:0]  dg,
    input  logic [DW-1:0] d,
    output logic [W-1:0]  res
);

    logic [W-1:0] travel;
    logic [W-1:0] gray;
    logic [W:0]   trav2;
    logic [2*W:0] prod;
    logic [2*W:0] fold;

    always_comb
    begin
        travel = (s ^ e) & msk;
        gray   = dg ^ (dg >> 1);
        trav2  = {travel, 1'b0};
        prod   = (2*W+1)'(gray) * (2*W+1)'(trav2);
        // fold the bits that leave the top back to the bottom
        fold   = prod | (prod >> d);
        res    = (fold[W-1:0] & msk) ^ s;
    end

endmodule

/* rtl/hic_step.sv */
module hic_step #(
    parameter int W  = 8,
    parameter int DW = 4
) (
    input  logic [W-1:0]  s,
    input  logic [W-1:0]  e,
    input  logic [W-1:0]  msk,
    input  logic [W-1:0]  dg,
    input  logic [DW-1:0] d,
    output logic [W-1:0]  res,
    output logic [W-1:0]  ns,
    output logic [W-1:0]  ne
);

    logic [W-1:0] lo;
    logic [W-1:0] hi;
    logic [W:0]   hi_raw;

    always_comb
    begin
        // child corners come from the even neighbour below and the odd one above
        if (dg == '0)
        begin
            lo = '0;
        end
        else
        begin
            lo = (dg - W'(1)) & ~W'(1);
        end
        hi_raw = ({1'b0, dg} + (W+1)'(1)) | (W+1)'(1);
        if (hi_raw > {1'b0, msk})
        begin
            hi = msk;
        end
        else
        begin
            hi = hi_raw[W-1:0];
        end
    end

    hic_gray_rot #(.W(W), .DW(DW)) u_rot_digit (
        .s   (s),
        .e   (e),
        .msk (msk),
        .dg  (dg),
        .d   (d),
        .res (res)
    );

    hic_gray_rot #(.W(W), .DW(DW)) u_rot_start (
        .s   (s),
        .e   (e),
        .msk (msk),
        .dg  (lo),
        .d   (d),
        .res (ns)
    );

    hic_gray_rot #(.W(W), .DW(DW)) u_rot_end (
        .s   (s),
        .e   (e),
        .msk (msk),
        .dg  (hi),
        .d   (d),
        .res (ne)
    );

endmodule

/* rtl/hilbert_index_to_coords.sv */
// a request counts its n = max(1, ceil(bits(index)/d)) digits in SEARCH, walks them
// in PROC, then emits d coordinates, one per cycle when not stalled, axis 0 first
// a new request is taken only in IDLE, once the previous one has emitted its last
// coordinate; digits are counted in a loop and walked by the shared digit step unit
// reset: asynchronous active low, dimensions back to 2, no request in flight
module hilbert_index_to_coords #(
    parameter int INDEX_BITS = 32,
    parameter int MAX_DIMS   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hic_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [INDEX_BITS-1:0]         index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hic_pkg::COORD_W-1:0]   coordinate,
    output logic [hic_pkg::AXIS_W-1:0]    axis,
    output logic                          last
);

    localparam int W  = MAX_DIMS;
    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NW = $clog2(INDEX_BITS + 1);
    localparam int VW = (INDEX_BITS > MAX_DIMS) ? INDEX_BITS : MAX_DIMS;
    localparam int XW = (INDEX_BITS > hic_pkg::COORD_W) ? INDEX_BITS : hic_pkg::COORD_W;
    localparam int XA = (AW > hic_pkg::AXIS_W) ? AW : hic_pkg::AXIS_W;

    hic_pkg::state_t state_reg, state_next;

    logic [hic_pkg::CFG_W-1:0] dims_reg;
    logic [INDEX_BITS-1:0]     v_reg;
    logic [NW-1:0]             count_reg;
    logic [AW-1:0]             rmod_reg;
    logic [AW-1:0]             j_reg;
    logic [W-1:0]              s_reg;
    logic [W-1:0]              e_reg;
    logic [W-1:0]              digs_reg [INDEX_BITS];
    logic [INDEX_BITS-1:0]     cbit_reg [MAX_DIMS];
    logic                      out_valid_reg;
    logic [hic_pkg::COORD_W-1:0] coord_reg;
    logic [AW-1:0]             axis_reg;
    logic                      last_reg;

    logic [DW-1:0]             d_eff;
    logic [W:0]                one_sh;
    logic [W-1:0]              msk;
    logic [INDEX_BITS-1:0]     v_shift;
    logic [VW-1:0]             v_ext;
    logic [W-1:0]              push_dig;
    logic [AW-1:0]             rmod_inc;
    logic [DW-1:0]             m_val;
    logic [W-1:0]              res;
    logic [W-1:0]              ns;
    logic [W-1:0]              ne;
    logic [AW-1:0]             sel_idx;
    logic [XW-1:0]             sel_ext;
    logic [XA-1:0]             axis_ext;
    logic                      j_last;
    logic                      emit_ok;

    logic accept_in;
    logic do_push;
    logic search_done;
    logic do_pop;
    logic load_out;

    // effective dimension count and digit mask
    always_comb
    begin
        if (dims_reg == '0)
        begin
            d_eff = DW'(1);
        end
        else if (int'(dims_reg) > MAX_DIMS)
        begin
            d_eff = DW'(MAX_DIMS);
        end
        else
        begin
            d_eff = DW'(dims_reg);
        end
        one_sh = (W+1)'(1) << d_eff;
        msk    = one_sh[W-1:0] - W'(1);
    end

    always_comb
    begin
        v_shift  = v_reg >> d_eff;
        v_ext    = VW'(v_reg);
        push_dig = v_ext[W-1:0] & msk;
        if ((DW'(rmod_reg) + DW'(1)) == d_eff)
        begin
            rmod_inc = '0;
        end
        else
        begin
            rmod_inc = rmod_reg + AW'(1);
        end
        if (rmod_reg == '0)
        begin
            m_val = '0;
        end
        else
        begin
            m_val = d_eff - DW'(rmod_reg);
        end
        j_last   = (DW'(j_reg) == (d_eff - DW'(1)));
        sel_idx  = AW'(d_eff - DW'(1) - DW'(j_reg));
        sel_ext  = XW'(cbit_reg[sel_idx]);
        axis_ext = XA'(axis_reg);
        emit_ok  = !out_valid_reg || !out_stall;
    end

    hic_step #(.W(W), .DW(DW)) u_step (
        .s   (s_reg),
        .e   (e_reg),
        .msk (msk),
        .dg  (digs_reg[0]),
        .d   (d_eff),
        .res (res),
        .ns  (ns),
        .ne  (ne)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hic_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hic_pkg::ST_SEARCH;
                end
            end
            hic_pkg::ST_SEARCH:
            begin
                if (v_shift == '0)
                begin
                    state_next = hic_pkg::ST_PROC;
                end
            end
            hic_pkg::ST_PROC:
            begin
                if (count_reg == NW'(1))
                begin
                    state_next = hic_pkg::ST_EMIT;
                end
            end
            hic_pkg::ST_EMIT:
            begin
                if (emit_ok && j_last)
                begin
                    state_next = hic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hic_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall    = 1'b1;
        accept_in   = 1'b0;
        do_push     = 1'b0;
        search_done = 1'b0;
        do_pop      = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            hic_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                accept_in = in_valid;
            end
            hic_pkg::ST_SEARCH:
            begin
                do_push     = 1'b1;
                search_done = (v_shift == '0);
            end
            hic_pkg::ST_PROC:
            begin
                do_pop = 1'b1;
            end
            hic_pkg::ST_EMIT:
            begin
                load_out = emit_ok;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hic_pkg::ST_IDLE;
            dims_reg      <= hic_pkg::DIMS_RESET;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            rmod_reg      <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                dims_reg <= cfg_data;
            end
            if (accept_in)
            begin
                count_reg <= '0;
                rmod_reg  <= (d_eff <= DW'(2)) ? AW'(0) : AW'(2);
                j_reg     <= '0;
            end
            else if (do_push)
            begin
                count_reg <= count_reg + NW'(1);
                rmod_reg  <= rmod_inc;
            end
            else if (do_pop)
            begin
                count_reg <= count_reg - NW'(1);
            end
            else if (load_out)
            begin
                j_reg <= j_reg + AW'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            v_reg <= index;
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                cbit_reg[k] <= '0;
            end
        end
        else if (do_push)
        begin
            v_reg       <= v_shift;
            digs_reg[0] <= push_dig;
            for (int i = 1; i < INDEX_BITS; i++)
            begin
                digs_reg[i] <= digs_reg[i-1];
            end
        end
        else if (do_pop)
        begin
            for (int i = 0; i < INDEX_BITS - 1; i++)
            begin
                digs_reg[i] <= digs_reg[i+1];
            end
            digs_reg[INDEX_BITS-1] <= '0;
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                cbit_reg[k] <= {cbit_reg[k][INDEX_BITS-2:0], res[k]};
            end
        end
        if (search_done)
        begin
            s_reg <= '0;
            e_reg <= W'(1) << m_val;
        end
        else if (do_pop)
        begin
            s_reg <= ns;
            e_reg <= ne;
        end
        if (load_out)
        begin
            coord_reg <= sel_ext[hic_pkg::COORD_W-1:0];
            axis_reg  <= j_reg;
            last_reg  <= j_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coordinate = coord_reg;
    assign axis       = axis_ext[hic_pkg::AXIS_W-1:0];
    assign last       = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> state_reg == hic_pkg::ST_SEARCH)
        else $error("request accepted without entering digit count");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hic_pkg::ST_PROC |-> count_reg != '0)
        else $error("digit walk with no digits left");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hic_pkg::ST_PROC |-> $onehot(s_reg ^ e_reg))
        else $error("start and end corners not adjacent");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> DW'(axis_reg) == (d_eff - DW'(1)))
        else $error("last coordinate not on the final axis");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hic_pkg::ST_EMIT |-> DW'(j_reg) < d_eff)
        else $error("axis counter beyond dimension count");

endmodule
